FILE: rtl/gfmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gfmc_pkg;

    // Fixed field widths
    localparam int GF_W     = 11;
    localparam int DIM_W    = 4;
    localparam int SAMPLE_W = 8;
    localparam int VAL_W    = 8;
    localparam int PSUM_W   = 9;
    localparam int WT_W     = 9;
    localparam int BASE_W   = 21;
    localparam int FADE_W   = 17;

    // APB register map
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam int DATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_GRAY_FACTOR = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_LOG2  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_LOG2 = 2'd2;

    localparam logic signed [GF_W-1:0] GF_RESET = 11'sd256;

    // Fade constants: 1.75 in 1/256 units, full weight, saturation maximum
    localparam int          FADE_STEP = 448;
    localparam logic [WT_W-1:0] WT_FULL = 9'd256;
    localparam logic [VAL_W-1:0] VAL_MAX = 8'hFF;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LVL  = 4'b0010,
        S_RD   = 4'b0100,
        S_FADE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/gray_fade_mipmap_chain_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming mipmap chain generator for a 2^width_log2 x 2^height_log2 luminance image
// given in raster order. Each sample is faded toward mid-gray by gray_factor and sent
// out as level 0; as 2x2 blocks (or pairs, once one side is 1) complete, the averaged
// pixel of the next level follows, faded by its level weight, levels in rising order,
// last set on the single top-level pixel. An item that completes no block is accepted
// and emitted; every further level it reaches adds a fade step for a pair average, and
// a store read then a fade step for a 2x2 average, as the sequencer walks one level
// at a time through the row-pair store read port and the fade multiplier. Output stalls hold
// the sequencer. A write to width_log2 or height_log2 restarts the image and
// recomputes the level weights with a bit-serial divider, during which s_ready stays low.
module gray_fade_mipmap_chain_unit #(
    parameter int MAX_DIM_LOG2 = 10
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,

    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [gfmc_pkg::ADDR_W-1:0]          paddr,
    input  wire  [gfmc_pkg::DATA_W-1:0]          pwdata,
    output logic [gfmc_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,

    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [gfmc_pkg::SAMPLE_W-1:0]        s_sample,

    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [$clog2(MAX_DIM_LOG2+1)-1:0]    m_level,
    output logic [MAX_DIM_LOG2-1:0]              m_col,
    output logic [MAX_DIM_LOG2-1:0]              m_row,
    output logic [gfmc_pkg::VAL_W-1:0]           m_value,
    output logic                                 m_last
);

    localparam int LV_W   = $clog2(MAX_DIM_LOG2 + 1);
    localparam int IDX_W  = (MAX_DIM_LOG2 > 1) ? $clog2(MAX_DIM_LOG2) : 1;
    localparam int DEPTH  = 1 << MAX_DIM_LOG2;
    localparam int NUM_W  = $clog2(MAX_DIM_LOG2 * gfmc_pkg::FADE_STEP + 1);
    localparam int BIT_W  = $clog2(NUM_W + 1);

    // ---------------- configuration registers ----------------
    logic signed [gfmc_pkg::GF_W-1:0]  gray_factor_reg;
    logic [gfmc_pkg::DIM_W-1:0]        width_log2_reg;
    logic [gfmc_pkg::DIM_W-1:0]        height_log2_reg;

    logic                              cfg_we;
    logic [gfmc_pkg::REG_IDX_W-1:0]    cfg_idx;
    logic                              dim_we;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[gfmc_pkg::ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;
    assign dim_we  = cfg_we && ((cfg_idx == gfmc_pkg::REG_WIDTH_LOG2) ||
                                (cfg_idx == gfmc_pkg::REG_HEIGHT_LOG2));

    always_comb begin
        unique case (cfg_idx)
            gfmc_pkg::REG_GRAY_FACTOR:
                prdata = {{(gfmc_pkg::DATA_W-gfmc_pkg::GF_W){1'b0}}, gray_factor_reg};
            gfmc_pkg::REG_WIDTH_LOG2:
                prdata = {{(gfmc_pkg::DATA_W-gfmc_pkg::DIM_W){1'b0}}, width_log2_reg};
            gfmc_pkg::REG_HEIGHT_LOG2:
                prdata = {{(gfmc_pkg::DATA_W-gfmc_pkg::DIM_W){1'b0}}, height_log2_reg};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_factor_reg <= gfmc_pkg::GF_RESET;
            width_log2_reg  <= '0;
            height_log2_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                gfmc_pkg::REG_GRAY_FACTOR: gray_factor_reg <= pwdata[gfmc_pkg::GF_W-1:0];
                gfmc_pkg::REG_WIDTH_LOG2:  width_log2_reg  <= pwdata[gfmc_pkg::DIM_W-1:0];
                gfmc_pkg::REG_HEIGHT_LOG2: height_log2_reg <= pwdata[gfmc_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated exponents and top level
    logic [LV_W-1:0] a_eff, b_eff, top_lvl;
    assign a_eff   = (width_log2_reg > gfmc_pkg::DIM_W'(MAX_DIM_LOG2)) ?
                     LV_W'(MAX_DIM_LOG2) : LV_W'(width_log2_reg);
    assign b_eff   = (height_log2_reg > gfmc_pkg::DIM_W'(MAX_DIM_LOG2)) ?
                     LV_W'(MAX_DIM_LOG2) : LV_W'(height_log2_reg);
    assign top_lvl = (a_eff > b_eff) ? a_eff : b_eff;

    // ---------------- per-level state ----------------
    logic [gfmc_pkg::VAL_W-1:0]   pending_reg   [MAX_DIM_LOG2];
    logic [MAX_DIM_LOG2-1:0]      level_col_reg [MAX_DIM_LOG2+1];
    logic [MAX_DIM_LOG2-1:0]      level_row_reg [MAX_DIM_LOG2+1];
    logic [gfmc_pkg::WT_W-1:0]    weight_reg    [MAX_DIM_LOG2];

    // Row-pair store: sync write, registered read
    logic [gfmc_pkg::PSUM_W-1:0]  pair_mem [DEPTH];
    logic [gfmc_pkg::PSUM_W-1:0]  pair_rd_reg;

    // ---------------- sequencer registers ----------------
    gfmc_pkg::state_t             state_reg, state_next;
    logic [LV_W-1:0]              lv_reg, lv_next;
    logic [gfmc_pkg::VAL_W-1:0]   chain_reg, chain_next;
    logic [gfmc_pkg::VAL_W-1:0]   shown_reg, shown_next;
    logic [gfmc_pkg::PSUM_W-1:0]  psum_reg, psum_next;

    logic                         m_valid_reg, m_valid_next;
    logic [LV_W-1:0]              m_level_reg, m_level_next;
    logic [MAX_DIM_LOG2-1:0]      m_col_reg, m_col_next;
    logic [MAX_DIM_LOG2-1:0]      m_row_reg, m_row_next;
    logic [gfmc_pkg::VAL_W-1:0]   m_value_reg, m_value_next;
    logic                         m_last_reg, m_last_next;

    // Weight engine registers
    logic                         wbusy_reg, wbusy_next;
    logic [IDX_W-1:0]             wk_reg, wk_next;
    logic [NUM_W-1:0]             wnum_reg, wnum_next;
    logic [NUM_W-1:0]             wdvd_reg, wdvd_next;
    logic [LV_W:0]                wrem_reg, wrem_next;
    logic [NUM_W-1:0]             wquo_reg, wquo_next;
    logic [BIT_W-1:0]             wbit_reg, wbit_next;

    assign s_ready = (state_reg == gfmc_pkg::S_IDLE) && !wbusy_reg;

    // ---------------- level-0 fade ----------------
    logic signed [gfmc_pkg::SAMPLE_W:0]     s_signed;
    logic signed [gfmc_pkg::BASE_W-1:0]     base_prod, base_bias, base_n;
    logic [gfmc_pkg::VAL_W-1:0]             base_val;

    assign s_signed  = $signed({1'b0, s_sample});
    assign base_prod = gfmc_pkg::BASE_W'(s_signed) * gfmc_pkg::BASE_W'(gray_factor_reg);
    assign base_bias = gfmc_pkg::BASE_W'(32768) -
                       (gfmc_pkg::BASE_W'(gray_factor_reg) <<< 7);
    assign base_n    = base_prod + base_bias;

    always_comb begin
        if (base_n[gfmc_pkg::BASE_W-1]) begin
            base_val = '0;
        end else if (|base_n[gfmc_pkg::BASE_W-2:16]) begin
            base_val = gfmc_pkg::VAL_MAX;
        end else begin
            base_val = base_n[15:8];
        end
    end

    // ---------------- current level geometry ----------------
    logic [IDX_W-1:0]             lv_idx;
    logic [MAX_DIM_LOG2-1:0]      cur_col, cur_row, col_lim, row_lim;
    logic [MAX_DIM_LOG2-1:0]      col_new, row_new, store_idx;
    logic [LV_W-1:0]              wl, hl;
    logic                         at_top, both_dims, odd_phase, out_free, lvl_go;
    logic [gfmc_pkg::VAL_W-1:0]   pend_cur;
    logic [gfmc_pkg::PSUM_W-1:0]  pair_sum;
    logic                         pend_we, store_we, store_re;

    assign lv_idx  = lv_reg[IDX_W-1:0];
    assign cur_col = level_col_reg[lv_reg];
    assign cur_row = level_row_reg[lv_reg];
    assign wl      = (a_eff > lv_reg) ? a_eff - lv_reg : '0;
    assign hl      = (b_eff > lv_reg) ? b_eff - lv_reg : '0;
    assign col_lim = MAX_DIM_LOG2'(((MAX_DIM_LOG2+1)'(1) << wl) - 1'b1);
    assign row_lim = MAX_DIM_LOG2'(((MAX_DIM_LOG2+1)'(1) << hl) - 1'b1);
    assign at_top  = (lv_reg == top_lvl);
    assign both_dims = (wl != '0) && (hl != '0);
    assign odd_phase = (both_dims || (wl != '0)) ? cur_col[0] : cur_row[0];
    assign pend_cur  = pending_reg[lv_idx];
    assign pair_sum  = gfmc_pkg::PSUM_W'(pend_cur) + gfmc_pkg::PSUM_W'(chain_reg);

    // Each level owns a region: offset DEPTH - DEPTH/2^lv
    assign store_idx = ~({MAX_DIM_LOG2{1'b1}} >> lv_reg) + (cur_col >> 1);

    assign col_new = (cur_col == col_lim) ? '0 : cur_col + 1'b1;
    assign row_new = (cur_col != col_lim) ? cur_row :
                     (cur_row == row_lim) ? '0 : cur_row + 1'b1;

    assign out_free = !m_valid_reg || m_ready;
    assign lvl_go   = (state_reg == gfmc_pkg::S_LVL) && out_free;
    assign pend_we  = lvl_go && !at_top && !odd_phase;
    assign store_we = lvl_go && !at_top && both_dims && cur_col[0] && !cur_row[0];
    assign store_re = lvl_go && !at_top && both_dims && cur_col[0] && cur_row[0];

    // ---------------- level fade ----------------
    logic [gfmc_pkg::WT_W-1:0]    wt_cur;
    logic [gfmc_pkg::FADE_W-1:0]  fade_prod;
    logic [gfmc_pkg::PSUM_W:0]    quad_sum;

    assign wt_cur    = weight_reg[lv_idx];
    assign fade_prod = gfmc_pkg::FADE_W'(chain_reg) *
                       gfmc_pkg::FADE_W'(gfmc_pkg::WT_FULL - wt_cur) +
                       (gfmc_pkg::FADE_W'(wt_cur) << 7);
    assign quad_sum  = (gfmc_pkg::PSUM_W+1)'(pair_rd_reg) + (gfmc_pkg::PSUM_W+1)'(psum_reg);

    always_comb begin
        state_next   = state_reg;
        lv_next      = lv_reg;
        chain_next   = chain_reg;
        shown_next   = shown_reg;
        psum_next    = psum_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_level_next = m_level_reg;
        m_col_next   = m_col_reg;
        m_row_next   = m_row_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            gfmc_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    lv_next    = '0;
                    chain_next = base_val;
                    shown_next = base_val;
                    state_next = gfmc_pkg::S_LVL;
                end
            end
            gfmc_pkg::S_LVL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_level_next = lv_reg;
                    m_col_next   = cur_col;
                    m_row_next   = cur_row;
                    m_value_next = shown_reg;
                    m_last_next  = at_top;
                    if (at_top || !odd_phase) begin
                        state_next = gfmc_pkg::S_IDLE;
                    end else if (both_dims) begin
                        if (cur_row[0]) begin
                            psum_next  = pair_sum;
                            state_next = gfmc_pkg::S_RD;
                        end else begin
                            state_next = gfmc_pkg::S_IDLE;
                        end
                    end else begin
                        chain_next = pair_sum[gfmc_pkg::PSUM_W-1:1];
                        state_next = gfmc_pkg::S_FADE;
                    end
                end
            end
            gfmc_pkg::S_RD: begin
                chain_next = quad_sum[gfmc_pkg::PSUM_W:2];
                state_next = gfmc_pkg::S_FADE;
            end
            gfmc_pkg::S_FADE: begin
                shown_next = fade_prod[15:8];
                lv_next    = lv_reg + 1'b1;
                state_next = gfmc_pkg::S_LVL;
            end
            default: begin
                state_next = gfmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gfmc_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        lv_reg      <= lv_next;
        chain_reg   <= chain_next;
        shown_reg   <= shown_next;
        psum_reg    <= psum_next;
        m_level_reg <= m_level_next;
        m_col_reg   <= m_col_next;
        m_row_reg   <= m_row_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;
    assign m_col   = m_col_reg;
    assign m_row   = m_row_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

    // Positions and held pixels; a dimension write restarts the image
    always_ff @(posedge aclk) begin
        if (!aresetn || dim_we) begin
            for (int i = 0; i < MAX_DIM_LOG2; i++) begin
                pending_reg[i] <= '0;
            end
            for (int i = 0; i <= MAX_DIM_LOG2; i++) begin
                level_col_reg[i] <= '0;
                level_row_reg[i] <= '0;
            end
        end else begin
            if (lvl_go) begin
                level_col_reg[lv_reg] <= col_new;
                level_row_reg[lv_reg] <= row_new;
            end
            if (pend_we) begin
                pending_reg[lv_idx] <= chain_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            pair_mem[store_idx] <= pair_sum;
        end
        if (store_re) begin
            pair_rd_reg <= pair_mem[store_idx];
        end
    end

    // ---------------- weight engine: min(256, k*448/top), bit-serial ----------------
    logic [LV_W:0]    wtrial;
    logic             wfit;
    logic [gfmc_pkg::WT_W-1:0] wt_res;

    assign wtrial = {wrem_reg[LV_W-1:0], wdvd_reg[NUM_W-1]};
    assign wfit   = (wtrial >= {1'b0, top_lvl});
    assign wt_res = (top_lvl == '0) ? '0 :
                    (wquo_reg > NUM_W'(gfmc_pkg::WT_FULL)) ? gfmc_pkg::WT_FULL :
                    gfmc_pkg::WT_W'(wquo_reg);

    always_comb begin
        wbusy_next = wbusy_reg;
        wk_next    = wk_reg;
        wnum_next  = wnum_reg;
        wdvd_next  = wdvd_reg;
        wrem_next  = wrem_reg;
        wquo_next  = wquo_reg;
        wbit_next  = wbit_reg;
        if (dim_we) begin
            wbusy_next = 1'b1;
            wk_next    = '0;
            wnum_next  = '0;
            wdvd_next  = '0;
            wrem_next  = '0;
            wquo_next  = '0;
            wbit_next  = BIT_W'(NUM_W);
        end else if (wbusy_reg) begin
            if (wbit_reg != '0) begin
                wrem_next = wfit ? wtrial - {1'b0, top_lvl} : wtrial;
                wquo_next = {wquo_reg[NUM_W-2:0], wfit};
                wdvd_next = wdvd_reg << 1;
                wbit_next = wbit_reg - 1'b1;
            end else if (wk_reg == IDX_W'(MAX_DIM_LOG2 - 1)) begin
                wbusy_next = 1'b0;
            end else begin
                wk_next   = wk_reg + 1'b1;
                wnum_next = wnum_reg + NUM_W'(gfmc_pkg::FADE_STEP);
                wdvd_next = wnum_reg + NUM_W'(gfmc_pkg::FADE_STEP);
                wrem_next = '0;
                wquo_next = '0;
                wbit_next = BIT_W'(NUM_W);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wbusy_reg <= 1'b0;
        end else begin
            wbusy_reg <= wbusy_next;
        end
        wk_reg   <= wk_next;
        wnum_reg <= wnum_next;
        wdvd_reg <= wdvd_next;
        wrem_reg <= wrem_next;
        wquo_reg <= wquo_next;
        wbit_reg <= wbit_next;
    end

    // Reset leaves top at zero, so every weight starts at zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIM_LOG2; i++) begin
                weight_reg[i] <= '0;
            end
        end else if (wbusy_reg && !dim_we && (wbit_reg == '0)) begin
            weight_reg[wk_reg] <= wt_res;
        end
    end

    // ---------------- assertions ----------------
    a_last_at_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_level == top_lvl))
        else $error("last flag on a level other than the top");

    a_rd_after_lvl: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gfmc_pkg::S_RD) |-> ($past(state_reg) == gfmc_pkg::S_LVL))
        else $error("store read phase without a preceding level step");

    a_fade_below_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gfmc_pkg::S_FADE) |-> (lv_reg < top_lvl))
        else $error("cascade past the top level");

endmodule

`default_nettype wire
